// ===== rtl/core/udcd_pkg.sv =====
`timescale 1ns / 1ps

package udcd_pkg;

  localparam int LINE_BUFFER_BYTES_DEF = 64;
  localparam int TIME_COUNTER_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int GROUP_MAX  = 3;
  localparam int PHASE_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WDOG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_CENTER   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSAL_DWELL = 2'd3;

  localparam logic [15:0] WDOG_TIMEOUT_RESET    = 16'd500;
  localparam logic [15:0] STATUS_INTERVAL_RESET = 16'd20;
  localparam logic [7:0]  STEER_CENTER_RESET    = 8'd90;
  localparam logic [7:0]  REVERSAL_DWELL_RESET  = 8'd30;
  localparam logic [7:0]  STEER_RESET           = 8'd90;
  localparam logic [7:0]  STEER_MAX             = 8'd180;
  localparam logic [7:0]  SPEED_MAX             = 8'd100;

  localparam logic [PHASE_W-1:0] PH_START = 4'd0;
  localparam logic [PHASE_W-1:0] PH_C     = 4'd1;
  localparam logic [PHASE_W-1:0] PH_WS1   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_SIGN1 = 4'd3;
  localparam logic [PHASE_W-1:0] PH_DIG1  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_WS2   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_SIGN2 = 4'd6;
  localparam logic [PHASE_W-1:0] PH_DIG2  = 4'd7;
  localparam logic [PHASE_W-1:0] PH_COK   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_CBAD  = 4'd9;
  localparam logic [PHASE_W-1:0] PH_E     = 4'd10;
  localparam logic [PHASE_W-1:0] PH_R     = 4'd11;
  localparam logic [PHASE_W-1:0] PH_UNK   = 4'd12;

  localparam logic [2:0] KIND_STOP      = 3'd0;
  localparam logic [2:0] KIND_FORWARD   = 3'd1;
  localparam logic [2:0] KIND_BACKWARD  = 3'd2;
  localparam logic [2:0] KIND_STEER     = 3'd3;
  localparam logic [2:0] KIND_ENC_RESET = 3'd4;
  localparam logic [2:0] KIND_BAD_C     = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN   = 3'd6;
  localparam logic [2:0] KIND_STATUS    = 3'd7;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         rx_byte;
    logic signed [31:0] encoder_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [6:0]         drive_duty;
    logic [7:0]         steer_angle;
    logic [7:0]         hold_ms;
    logic signed [7:0]  report_speed;
    logic [7:0]         report_steer;
    logic signed [31:0] report_encoder;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] wdog_timeout;
    logic [15:0] status_interval;
    logic [7:0]  steer_center;
    logic [7:0]  reversal_dwell;
  } cfg_t;

  typedef struct packed {
    logic               exec;
    logic [PHASE_W-1:0] phase;
    logic [7:0]         first_value;
    logic               first_neg;
    logic [7:0]         second_value;
    logic               second_neg;
  } line_evt_t;

endpackage

// ===== rtl/core/udcd_line_parser.sv =====
`timescale 1ns / 1ps

module udcd_line_parser #(
  parameter int LINE_BUFFER_BYTES = udcd_pkg::LINE_BUFFER_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                commit_i,
  input  udcd_pkg::in_item_t  item_i,
  output udcd_pkg::line_evt_t evt_o
);

  localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BUFFER_BYTES - 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;

  function automatic logic [7:0] accumulate(input logic [7:0] v, input logic [7:0] b);
    logic [11:0] t;
    t = {4'b0, v} * 12'd10 + {4'b0, b - CH_ZERO};
    return (t > 12'd255) ? 8'hFF : t[7:0];
  endfunction

  logic [LEN_W-1:0]             len_q, len_d;
  logic [udcd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic                         ended_q, ended_d;
  logic [7:0]                   v1_q, v1_d, v2_q, v2_d;
  logic                         n1_q, n1_d, n2_q, n2_d;

  logic [7:0] b;
  logic       is_blank, is_digit, is_sign, is_term, exec;

  assign b        = item_i.rx_byte;
  assign is_blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
  assign is_term  = (b == CH_LF) || (b == CH_CR);

  always_comb begin
    len_d   = len_q;
    phase_d = phase_q;
    ended_d = ended_q;
    v1_d    = v1_q;
    n1_d    = n1_q;
    v2_d    = v2_q;
    n2_d    = n2_q;
    exec    = 1'b0;
    if (is_term || (len_q >= LEN_LIMIT)) begin
      if (is_term) begin
        exec = (len_q != '0);
      end
      if (!is_term || (len_q != '0)) begin
        len_d   = '0;
        phase_d = udcd_pkg::PH_START;
        ended_d = 1'b0;
        v1_d    = '0;
        n1_d    = 1'b0;
        v2_d    = '0;
        n2_d    = 1'b0;
      end
    end else begin
      len_d = len_q + 1'b1;
      if (!ended_q) begin
        if (b == CH_NUL) begin
          ended_d = 1'b1;
        end else begin
          unique case (phase_q)
            udcd_pkg::PH_START: begin
              phase_d = (b == CH_C) ? udcd_pkg::PH_C :
                        (b == CH_E) ? udcd_pkg::PH_E :
                        (b == CH_R) ? udcd_pkg::PH_R : udcd_pkg::PH_UNK;
            end
            udcd_pkg::PH_C: begin
              phase_d = (b == CH_COLON) ? udcd_pkg::PH_WS1 : udcd_pkg::PH_UNK;
            end
            udcd_pkg::PH_WS1, udcd_pkg::PH_SIGN1: begin
              if (phase_q == udcd_pkg::PH_WS1 && is_blank) begin
                phase_d = phase_q;
              end else if (phase_q == udcd_pkg::PH_WS1 && is_sign) begin
                n1_d    = (b == CH_MINUS);
                phase_d = udcd_pkg::PH_SIGN1;
              end else if (is_digit) begin
                v1_d    = accumulate(v1_q, b);
                phase_d = udcd_pkg::PH_DIG1;
              end else begin
                phase_d = udcd_pkg::PH_CBAD;
              end
            end
            udcd_pkg::PH_DIG1: begin
              if (is_digit) begin
                v1_d = accumulate(v1_q, b);
              end else begin
                phase_d = (b == CH_COMMA) ? udcd_pkg::PH_WS2 : udcd_pkg::PH_CBAD;
              end
            end
            udcd_pkg::PH_WS2, udcd_pkg::PH_SIGN2: begin
              if (phase_q == udcd_pkg::PH_WS2 && is_blank) begin
                phase_d = phase_q;
              end else if (phase_q == udcd_pkg::PH_WS2 && is_sign) begin
                n2_d    = (b == CH_MINUS);
                phase_d = udcd_pkg::PH_SIGN2;
              end else if (is_digit) begin
                v2_d    = accumulate(v2_q, b);
                phase_d = udcd_pkg::PH_DIG2;
              end else begin
                phase_d = udcd_pkg::PH_CBAD;
              end
            end
            udcd_pkg::PH_DIG2: begin
              if (is_digit) begin
                v2_d = accumulate(v2_q, b);
              end else begin
                phase_d = udcd_pkg::PH_COK;
              end
            end
            udcd_pkg::PH_E, udcd_pkg::PH_R: begin
              phase_d = udcd_pkg::PH_UNK;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      phase_q <= udcd_pkg::PH_START;
      ended_q <= 1'b0;
      v1_q    <= '0;
      n1_q    <= 1'b0;
      v2_q    <= '0;
      n2_q    <= 1'b0;
    end else if (commit_i && (item_i.opcode == udcd_pkg::OP_BYTE)) begin
      len_q   <= len_d;
      phase_q <= phase_d;
      ended_q <= ended_d;
      v1_q    <= v1_d;
      n1_q    <= n1_d;
      v2_q    <= v2_d;
      n2_q    <= n2_d;
    end
  end

  assign evt_o.exec         = exec && (item_i.opcode == udcd_pkg::OP_BYTE);
  assign evt_o.phase        = phase_q;
  assign evt_o.first_value  = v1_q;
  assign evt_o.first_neg    = n1_q;
  assign evt_o.second_value = v2_q;
  assign evt_o.second_neg   = n2_q;

endmodule

// ===== rtl/core/udcd_drive_ctrl.sv =====
`timescale 1ns / 1ps

module udcd_drive_ctrl #(
  parameter int TIME_COUNTER_BITS = udcd_pkg::TIME_COUNTER_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            commit_i,
  input  udcd_pkg::in_item_t              item_i,
  input  udcd_pkg::line_evt_t             evt_i,
  input  udcd_pkg::cfg_t                  cfg_i,
  output udcd_pkg::out_item_t [2:0]       grp_o,
  output logic [1:0]                      cnt_o
);

  localparam int CMP_W = (TIME_COUNTER_BITS > 16) ? TIME_COUNTER_BITS : 16;

  logic signed [7:0]            speed_q, speed_d;
  logic [7:0]                   steer_q, steer_d;
  logic [1:0]                   dir_q, dir_d;
  logic                         fired_q, fired_d;
  logic [TIME_COUNTER_BITS-1:0] cmd_ms_q, cmd_ms_d, stat_ms_q, stat_ms_d;

  logic [TIME_COUNTER_BITS-1:0] cmd_inc, stat_inc;
  logic                         wd_fire, stat_fire;
  logic [6:0]                   mag;
  logic signed [7:0]            spd_new;
  logic [1:0]                   dir_new;
  logic [7:0]                   steer_new, center;
  logic                         reversal;

  udcd_pkg::out_item_t [2:0] cand;
  logic [2:0]                en;
  udcd_pkg::out_item_t [2:0] grp;
  logic [1:0]                n;

  function automatic udcd_pkg::out_item_t make_res(input logic [2:0] kind,
                                                   input logic [6:0] duty,
                                                   input logic [7:0] angle,
                                                   input logic [7:0] hold);
    udcd_pkg::out_item_t r;
    r             = '0;
    r.kind        = kind;
    r.drive_duty  = duty;
    r.steer_angle = angle;
    r.hold_ms     = hold;
    return r;
  endfunction

  assign cmd_inc   = (cmd_ms_q == '1) ? cmd_ms_q : cmd_ms_q + 1'b1;
  assign stat_inc  = (stat_ms_q == '1) ? stat_ms_q : stat_ms_q + 1'b1;
  assign wd_fire   = !fired_q && (CMP_W'(cmd_inc) > CMP_W'(cfg_i.wdog_timeout));
  assign stat_fire = CMP_W'(stat_inc) >= CMP_W'(cfg_i.status_interval);

  assign mag       = (evt_i.first_value > udcd_pkg::SPEED_MAX) ? udcd_pkg::SPEED_MAX[6:0]
                                                               : evt_i.first_value[6:0];
  assign spd_new   = evt_i.first_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign dir_new   = (mag == '0) ? udcd_pkg::DIR_STOP :
                     evt_i.first_neg ? udcd_pkg::DIR_BWD : udcd_pkg::DIR_FWD;
  assign steer_new = evt_i.second_neg ? 8'd0 :
                     (evt_i.second_value > udcd_pkg::STEER_MAX) ? udcd_pkg::STEER_MAX
                                                                 : evt_i.second_value;
  assign center    = (cfg_i.steer_center > udcd_pkg::STEER_MAX) ? udcd_pkg::STEER_MAX
                                                                 : cfg_i.steer_center;
  assign reversal  = ((dir_q == udcd_pkg::DIR_FWD) && (dir_new == udcd_pkg::DIR_BWD)) ||
                     ((dir_q == udcd_pkg::DIR_BWD) && (dir_new == udcd_pkg::DIR_FWD));

  always_comb begin
    cand      = '0;
    en        = '0;
    speed_d   = speed_q;
    steer_d   = steer_q;
    dir_d     = dir_q;
    fired_d   = fired_q;
    cmd_ms_d  = cmd_ms_q;
    stat_ms_d = stat_ms_q;
    if (item_i.opcode == udcd_pkg::OP_TICK) begin
      cmd_ms_d  = cmd_inc;
      stat_ms_d = stat_inc;
      if (wd_fire) begin
        en[0]   = 1'b1;
        cand[0] = make_res(udcd_pkg::KIND_STOP, '0, '0, '0);
        speed_d = '0;
        dir_d   = udcd_pkg::DIR_STOP;
        fired_d = 1'b1;
      end
      if (stat_fire) begin
        en[1]                  = 1'b1;
        cand[1]                = make_res(udcd_pkg::KIND_STATUS, '0, '0, '0);
        cand[1].report_speed   = wd_fire ? 8'sd0 : speed_q;
        cand[1].report_steer   = steer_q;
        cand[1].report_encoder = item_i.encoder_count;
        stat_ms_d              = '0;
      end
    end else if (evt_i.exec) begin
      cmd_ms_d = '0;
      fired_d  = 1'b0;
      unique case (evt_i.phase)
        udcd_pkg::PH_DIG2, udcd_pkg::PH_COK: begin
          if (spd_new != speed_q) begin
            en[0]   = reversal;
            cand[0] = make_res(udcd_pkg::KIND_STOP, '0, '0, cfg_i.reversal_dwell);
            en[1]   = 1'b1;
            unique case (dir_new)
              udcd_pkg::DIR_FWD: cand[1] = make_res(udcd_pkg::KIND_FORWARD, mag, '0, '0);
              udcd_pkg::DIR_BWD: cand[1] = make_res(udcd_pkg::KIND_BACKWARD, mag, '0, '0);
              default:           cand[1] = make_res(udcd_pkg::KIND_STOP, '0, '0, '0);
            endcase
            speed_d = spd_new;
            dir_d   = dir_new;
          end
          if (steer_new != steer_q) begin
            en[2]   = 1'b1;
            cand[2] = make_res(udcd_pkg::KIND_STEER, '0, steer_new, '0);
            steer_d = steer_new;
          end
        end
        udcd_pkg::PH_E: begin
          en[0]   = 1'b1;
          cand[0] = make_res(udcd_pkg::KIND_STOP, '0, '0, '0);
          en[1]   = 1'b1;
          cand[1] = make_res(udcd_pkg::KIND_STEER, '0, center, '0);
          speed_d = '0;
          dir_d   = udcd_pkg::DIR_STOP;
          steer_d = center;
        end
        udcd_pkg::PH_R: begin
          en[0]   = 1'b1;
          cand[0] = make_res(udcd_pkg::KIND_ENC_RESET, '0, '0, '0);
        end
        udcd_pkg::PH_WS1, udcd_pkg::PH_SIGN1, udcd_pkg::PH_DIG1,
        udcd_pkg::PH_WS2, udcd_pkg::PH_SIGN2, udcd_pkg::PH_CBAD: begin
          en[0]   = 1'b1;
          cand[0] = make_res(udcd_pkg::KIND_BAD_C, '0, '0, '0);
        end
        default: begin
          en[0]   = 1'b1;
          cand[0] = make_res(udcd_pkg::KIND_UNKNOWN, '0, '0, '0);
        end
      endcase
    end
  end

  // pack enabled results toward slot 0 and flag the final one
  always_comb begin
    grp = '0;
    n   = '0;
    for (int k = 0; k < udcd_pkg::GROUP_MAX; k++) begin
      if (en[k]) begin
        grp[n] = cand[k];
        n      = n + 1'b1;
      end
    end
    for (int i = 0; i < udcd_pkg::GROUP_MAX; i++) begin
      grp[i].last = (n == 2'(i + 1));
    end
  end

  assign grp_o = grp;
  assign cnt_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q   <= '0;
      steer_q   <= udcd_pkg::STEER_RESET;
      dir_q     <= udcd_pkg::DIR_STOP;
      fired_q   <= 1'b0;
      cmd_ms_q  <= '0;
      stat_ms_q <= '0;
    end else if (commit_i) begin
      speed_q   <= speed_d;
      steer_q   <= steer_d;
      dir_q     <= dir_d;
      fired_q   <= fired_d;
      cmd_ms_q  <= cmd_ms_d;
      stat_ms_q <= stat_ms_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_dir_matches_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((dir_q == udcd_pkg::DIR_FWD) == (speed_q > 8'sd0)) &&
    ((dir_q == udcd_pkg::DIR_BWD) == (speed_q < 8'sd0)))
    else $error("motor direction disagrees with commanded speed");

  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (speed_q <= 8'sd100) && (speed_q >= -8'sd100) && (steer_q <= udcd_pkg::STEER_MAX))
    else $error("commanded speed or steering out of range");

  a_fired_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && wd_fire && (item_i.opcode == udcd_pkg::OP_TICK)) |=>
    fired_q && (speed_q == 8'sd0))
    else $error("watchdog stop did not latch");
`endif

endmodule

// ===== rtl/core/udcd_result_buf.sv =====
`timescale 1ns / 1ps

module udcd_result_buf (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  udcd_pkg::out_item_t [2:0] grp_i,
  input  logic [1:0]                cnt_i,
  output logic                      free_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output udcd_pkg::out_item_t       out_item_o
);

  udcd_pkg::out_item_t [2:0] buf_q;
  logic [1:0]                cnt_q;
  logic                      take;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = buf_q[0];
  assign take        = out_valid_o && !out_stall_i;
  assign free_o      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= cnt_i;
    end else if (take) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // shift the group down one beat at a time
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= grp_i;
    end else if (take) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result group overwritten before it drained");

  a_tail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> buf_q[0].last)
    else $error("final beat of a group lacks last");
`endif

endmodule

// ===== rtl/core/uart_drive_command_decoder_top.sv =====
`timescale 1ns / 1ps

// UART drive command decoder.
// Input channel (in_valid_i / in_stall_o / in_item_i): one beat is either a
// received UART byte or a one-millisecond tick carrying the encoder count.
// Output channel (out_valid_o / out_stall_i / out_item_o): drive, steer,
// encoder reset, error and status results; last marks the final result of
// the input beat that caused it. Most beats cause no result; at most three.
// An accepted beat is registered in the input register, then decoded
// combinationally into the result group register, from which its first
// result is offered. Throughput: one input beat per cycle while each beat
// yields at most one result and out_stall_i is low; a beat with several
// results holds the group, which drains one result per unstalled cycle.
// While the receiver stalls, the current result holds and the input register
// fills, after which in_stall_o rises; nothing is dropped.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 watchdog timeout, 1 status interval, 2 steering center, 3 reversal
// dwell); write only while idle.
// Reset clears the line parser, sets speed 0 and steering 90, clears both
// millisecond counters and loads the configuration defaults.

module uart_drive_command_decoder_top #(
  parameter int LINE_BUFFER_BYTES = udcd_pkg::LINE_BUFFER_BYTES_DEF,
  parameter int TIME_COUNTER_BITS = udcd_pkg::TIME_COUNTER_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  udcd_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output udcd_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [udcd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [udcd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  udcd_pkg::cfg_t            cfg_q;
  logic                      in_vld_q;
  udcd_pkg::in_item_t        in_q;
  logic                      free, commit, accept;
  udcd_pkg::line_evt_t       evt;
  udcd_pkg::out_item_t [2:0] grp;
  logic [1:0]                cnt;

  assign commit     = in_vld_q && free;
  assign in_stall_o = in_vld_q && !free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (commit) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wdog_timeout    <= udcd_pkg::WDOG_TIMEOUT_RESET;
      cfg_q.status_interval <= udcd_pkg::STATUS_INTERVAL_RESET;
      cfg_q.steer_center    <= udcd_pkg::STEER_CENTER_RESET;
      cfg_q.reversal_dwell  <= udcd_pkg::REVERSAL_DWELL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        udcd_pkg::REG_WDOG_TIMEOUT:    cfg_q.wdog_timeout    <= cfg_data_i;
        udcd_pkg::REG_STATUS_INTERVAL: cfg_q.status_interval <= cfg_data_i;
        udcd_pkg::REG_STEER_CENTER:    cfg_q.steer_center    <= cfg_data_i[7:0];
        udcd_pkg::REG_REVERSAL_DWELL:  cfg_q.reversal_dwell  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  udcd_line_parser #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .item_i   (in_q),
    .evt_o    (evt)
  );

  udcd_drive_ctrl #(
    .TIME_COUNTER_BITS (TIME_COUNTER_BITS)
  ) u_drive (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (commit),
    .item_i   (in_q),
    .evt_i    (evt),
    .cfg_i    (cfg_q),
    .grp_o    (grp),
    .cnt_o    (cnt)
  );

  udcd_result_buf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (commit),
    .grp_i       (grp),
    .cnt_i       (cnt),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TICK_MAX = (1 << udcd_pkg::TIME_COUNTER_BITS_DEF) - 1;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam udcd_pkg::out_item_t NO_RES = '0;

  typedef struct {
    logic                tick;
    int                  reps;
    string               text;
    logic [31:0]         enc;
    logic                typed;
    logic                want_one;
    udcd_pkg::out_item_t want;
  } script_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  udcd_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  udcd_pkg::out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [udcd_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [udcd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  uart_drive_command_decoder_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // decoder mirror state
  int          ln_len;
  logic [3:0]  ph;
  bit          ended;
  int          v1, v2;
  bit          n1, n2;
  int          cur_speed, cur_steer;
  logic [1:0]  cur_dir;
  bit          wd_fired;
  int          ms_cmd, ms_stat;
  int          cfg_wdog, cfg_stat, cfg_center, cfg_dwell;

  udcd_pkg::out_item_t beat_results[$];
  udcd_pkg::out_item_t pending_results[$];
  logic [7:0]          line_buf[$];
  script_row_t         script[$];

  int fail_cnt = 0;
  int beats_sent = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int hold_order = 0;
  int hold_served = 0;
  int hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic udcd_pkg::out_item_t res_of(logic [2:0] k, int duty, int ang, int hold);
    udcd_pkg::out_item_t r;
    r = '0;
    r.kind = k;
    r.drive_duty = duty[6:0];
    r.steer_angle = ang[7:0];
    r.hold_ms = hold[7:0];
    return r;
  endfunction

  function automatic udcd_pkg::out_item_t status_res(int spd, int st, logic [31:0] enc);
    udcd_pkg::out_item_t r;
    r = res_of(udcd_pkg::KIND_STATUS, 0, 0, 0);
    r.report_speed = spd[7:0];
    r.report_steer = st[7:0];
    r.report_encoder = enc;
    return r;
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0B || b == 8'h0C;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_sign(logic [7:0] b);
    return b == "-" || b == "+";
  endfunction

  function automatic int accum(int v, logic [7:0] b);
    int t;
    t = v * 10 + (int'(b) - 48);
    return t > 255 ? 255 : t;
  endfunction

  function void clear_line();
    ln_len = 0;
    ph = udcd_pkg::PH_START;
    ended = 1'b0;
    v1 = 0;
    n1 = 1'b0;
    v2 = 0;
    n2 = 1'b0;
  endfunction

  function void reset_mirror();
    clear_line();
    cur_speed = 0;
    cur_steer = int'(udcd_pkg::STEER_RESET);
    cur_dir = udcd_pkg::DIR_STOP;
    wd_fired = 1'b0;
    ms_cmd = 0;
    ms_stat = 0;
    cfg_wdog = int'(udcd_pkg::WDOG_TIMEOUT_RESET);
    cfg_stat = int'(udcd_pkg::STATUS_INTERVAL_RESET);
    cfg_center = int'(udcd_pkg::STEER_CENTER_RESET);
    cfg_dwell = int'(udcd_pkg::REVERSAL_DWELL_RESET);
  endfunction

  function void parse_char(logic [7:0] b);
    case (ph)
      udcd_pkg::PH_START: ph = (b == "C") ? udcd_pkg::PH_C :
                               (b == "E") ? udcd_pkg::PH_E :
                               (b == "R") ? udcd_pkg::PH_R : udcd_pkg::PH_UNK;
      udcd_pkg::PH_C: ph = (b == ":") ? udcd_pkg::PH_WS1 : udcd_pkg::PH_UNK;
      udcd_pkg::PH_WS1, udcd_pkg::PH_SIGN1: begin
        if (ph == udcd_pkg::PH_WS1 && is_sign(b)) begin
          n1 = (b == "-");
          ph = udcd_pkg::PH_SIGN1;
        end else if (!(ph == udcd_pkg::PH_WS1 && is_blank(b))) begin
          if (is_digit(b)) begin
            v1 = accum(v1, b);
            ph = udcd_pkg::PH_DIG1;
          end else begin
            ph = udcd_pkg::PH_CBAD;
          end
        end
      end
      udcd_pkg::PH_DIG1: begin
        if (is_digit(b)) v1 = accum(v1, b);
        else ph = (b == ",") ? udcd_pkg::PH_WS2 : udcd_pkg::PH_CBAD;
      end
      udcd_pkg::PH_WS2, udcd_pkg::PH_SIGN2: begin
        if (ph == udcd_pkg::PH_WS2 && is_sign(b)) begin
          n2 = (b == "-");
          ph = udcd_pkg::PH_SIGN2;
        end else if (!(ph == udcd_pkg::PH_WS2 && is_blank(b))) begin
          if (is_digit(b)) begin
            v2 = accum(v2, b);
            ph = udcd_pkg::PH_DIG2;
          end else begin
            ph = udcd_pkg::PH_CBAD;
          end
        end
      end
      udcd_pkg::PH_DIG2: begin
        if (is_digit(b)) v2 = accum(v2, b);
        else ph = udcd_pkg::PH_COK;
      end
      udcd_pkg::PH_E, udcd_pkg::PH_R: ph = udcd_pkg::PH_UNK;
      default: ;
    endcase
  endfunction

  function void apply_drive();
    int spd, st;
    logic [1:0] nd;
    spd = n1 ? -v1 : v1;
    st = n2 ? 0 : v2;
    if (spd < -int'(udcd_pkg::SPEED_MAX)) spd = -int'(udcd_pkg::SPEED_MAX);
    if (spd > int'(udcd_pkg::SPEED_MAX)) spd = int'(udcd_pkg::SPEED_MAX);
    if (st > int'(udcd_pkg::STEER_MAX)) st = int'(udcd_pkg::STEER_MAX);
    if (spd != cur_speed) begin
      nd = spd > 0 ? udcd_pkg::DIR_FWD : spd < 0 ? udcd_pkg::DIR_BWD : udcd_pkg::DIR_STOP;
      if ((cur_dir == udcd_pkg::DIR_FWD && nd == udcd_pkg::DIR_BWD) ||
          (cur_dir == udcd_pkg::DIR_BWD && nd == udcd_pkg::DIR_FWD))
        beat_results.push_back(res_of(udcd_pkg::KIND_STOP, 0, 0, cfg_dwell));
      cur_dir = nd;
      if (spd > 0) beat_results.push_back(res_of(udcd_pkg::KIND_FORWARD, spd, 0, 0));
      else if (spd < 0) beat_results.push_back(res_of(udcd_pkg::KIND_BACKWARD, -spd, 0, 0));
      else beat_results.push_back(res_of(udcd_pkg::KIND_STOP, 0, 0, 0));
      cur_speed = spd;
    end
    if (st != cur_steer) begin
      beat_results.push_back(res_of(udcd_pkg::KIND_STEER, 0, st, 0));
      cur_steer = st;
    end
  endfunction

  function void run_line();
    int c;
    ms_cmd = 0;
    wd_fired = 1'b0;
    case (ph)
      udcd_pkg::PH_DIG2, udcd_pkg::PH_COK: apply_drive();
      udcd_pkg::PH_E: begin
        c = cfg_center > int'(udcd_pkg::STEER_MAX) ? int'(udcd_pkg::STEER_MAX) : cfg_center;
        beat_results.push_back(res_of(udcd_pkg::KIND_STOP, 0, 0, 0));
        beat_results.push_back(res_of(udcd_pkg::KIND_STEER, 0, c, 0));
        cur_speed = 0;
        cur_dir = udcd_pkg::DIR_STOP;
        cur_steer = c;
      end
      udcd_pkg::PH_R: beat_results.push_back(res_of(udcd_pkg::KIND_ENC_RESET, 0, 0, 0));
      udcd_pkg::PH_WS1, udcd_pkg::PH_SIGN1, udcd_pkg::PH_DIG1,
      udcd_pkg::PH_WS2, udcd_pkg::PH_SIGN2, udcd_pkg::PH_CBAD:
        beat_results.push_back(res_of(udcd_pkg::KIND_BAD_C, 0, 0, 0));
      default: beat_results.push_back(res_of(udcd_pkg::KIND_UNKNOWN, 0, 0, 0));
    endcase
  endfunction

  function void decode_beat(udcd_pkg::in_item_t it);
    udcd_pkg::out_item_t r;
    beat_results.delete();
    if (it.opcode == udcd_pkg::OP_TICK) begin
      if (ms_cmd < TICK_MAX) ms_cmd++;
      if (ms_stat < TICK_MAX) ms_stat++;
      if (!wd_fired && ms_cmd > cfg_wdog) begin
        beat_results.push_back(res_of(udcd_pkg::KIND_STOP, 0, 0, 0));
        cur_speed = 0;
        cur_dir = udcd_pkg::DIR_STOP;
        wd_fired = 1'b1;
      end
      if (ms_stat >= cfg_stat) begin
        beat_results.push_back(status_res(cur_speed, cur_steer, it.encoder_count));
        ms_stat = 0;
      end
    end else if (it.rx_byte == CH_LF || it.rx_byte == CH_CR) begin
      if (ln_len > 0) begin
        run_line();
        clear_line();
      end
    end else if (ln_len < udcd_pkg::LINE_BUFFER_BYTES_DEF - 1) begin
      ln_len++;
      if (!ended) begin
        if (it.rx_byte == CH_NUL) ended = 1'b1;
        else parse_char(it.rx_byte);
      end
    end else begin
      clear_line();
    end
    if (beat_results.size() > 0) begin
      r = beat_results.pop_back();
      r.last = 1'b1;
      beat_results.push_back(r);
    end
  endfunction

  function automatic udcd_pkg::in_item_t tick_of(logic [31:0] enc);
    udcd_pkg::in_item_t it;
    it.opcode = udcd_pkg::OP_TICK;
    it.rx_byte = 8'($urandom_range(0, 255));
    it.encoder_count = enc;
    return it;
  endfunction

  function automatic udcd_pkg::in_item_t byte_of(logic [7:0] b);
    udcd_pkg::in_item_t it;
    it.opcode = udcd_pkg::OP_BYTE;
    it.rx_byte = b;
    it.encoder_count = $urandom;
    return it;
  endfunction

  task automatic send_beat(udcd_pkg::in_item_t it, bit typed, bit want_one,
                           udcd_pkg::out_item_t want);
    udcd_pkg::out_item_t w;
    while (!quiet && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    decode_beat(it);
    if (typed) begin
      beat_results.delete();
      if (want_one) begin
        w = want;
        w.last = 1'b1;
        beat_results.push_back(w);
      end
    end
    foreach (beat_results[i]) pending_results.push_back(beat_results[i]);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_buf(bit mix_ticks);
    for (int i = 0; i < line_buf.size(); i++) begin
      if (mix_ticks && $urandom_range(0, 99) < 5)
        send_beat(tick_of($urandom), 1'b0, 1'b0, NO_RES);
      send_beat(byte_of(line_buf[i]), 1'b0, 1'b0, NO_RES);
    end
  endtask

  function void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function void put_noise(int n, bit printable);
    repeat (n) line_buf.push_back(8'(printable ? $urandom_range(8'h21, 8'h7E)
                                               : $urandom_range(0, 255)));
  endfunction

  function void put_number(bit is_speed);
    int k, v;
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
      case ($urandom_range(0, 3))
        0: line_buf.push_back(8'h20);
        1: line_buf.push_back(8'h09);
        2: line_buf.push_back(8'h0B);
        default: line_buf.push_back(8'h0C);
      endcase
    end
    k = $urandom_range(0, 9);
    if (k < 4) line_buf.push_back("-");
    else if (k < 6) line_buf.push_back("+");
    k = $urandom_range(0, 9);
    if (k < 7) v = $urandom_range(0, is_speed ? 110 : 190);
    else if (k < 9) v = $urandom_range(0, 999);
    else v = $urandom_range(0, 99999999);
    if ($urandom_range(0, 9) == 0) line_buf.push_back("0");
    put_text($sformatf("%0d", v));
  endfunction

  function void build_line();
    int pick, cut;
    line_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      put_text("C:");
      put_number(1'b1);
      line_buf.push_back(",");
      put_number(1'b0);
      if ($urandom_range(0, 4) == 0) put_noise($urandom_range(1, 4), 1'b0);
      // corrupt a share of the commands
      if (pick >= 52) begin
        if ($urandom_range(0, 1) == 0) begin
          cut = $urandom_range(1, line_buf.size() - 1);
          while (line_buf.size() > cut) void'(line_buf.pop_back());
        end else begin
          line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
      end
    end else if (pick < 76) begin
      line_buf.push_back(pick < 68 ? "E" : "R");
      cut = $urandom_range(0, 9);
      if (cut < 3) begin
        line_buf.push_back(CH_NUL);
        put_noise($urandom_range(0, 3), 1'b0);
      end else if (cut == 3) begin
        put_noise(1, 1'b1);
      end
    end else if (pick < 86) begin
      put_noise($urandom_range(1, 8), 1'b0);
    end else if (pick < 92) begin
      put_noise($urandom_range(60, 70), 1'b1);
    end else if (pick >= 96) begin
      put_text("C:");
      put_noise($urandom_range(0, 4), 1'b0);
    end
    line_buf.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
  endfunction

  task automatic run_random(int beat_goal, int max_ticks);
    int b0;
    b0 = beats_sent;
    while (beats_sent - b0 < beat_goal) begin
      build_line();
      send_buf(1'b1);
      repeat ($urandom_range(0, max_ticks)) send_beat(tick_of($urandom), 1'b0, 1'b0, NO_RES);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic configure(int wdog, int stat, int center, int dwell);
    cfg_we_i <= 1'b1;
    cfg_index_i <= udcd_pkg::REG_WDOG_TIMEOUT;
    cfg_data_i <= wdog[15:0];
    @(negedge clk_i);
    cfg_index_i <= udcd_pkg::REG_STATUS_INTERVAL;
    cfg_data_i <= stat[15:0];
    @(negedge clk_i);
    cfg_index_i <= udcd_pkg::REG_STEER_CENTER;
    cfg_data_i <= {8'h00, center[7:0]};
    @(negedge clk_i);
    cfg_index_i <= udcd_pkg::REG_REVERSAL_DWELL;
    cfg_data_i <= {8'h00, dwell[7:0]};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_wdog = wdog & 16'hFFFF;
    cfg_stat = stat & 16'hFFFF;
    cfg_center = center & 8'hFF;
    cfg_dwell = dwell & 8'hFF;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    script_row_t row;
    logic [7:0] ch;
    udcd_pkg::in_item_t it;
    int n;
    reset_mirror();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // '~' stands for a NUL byte in the text column
    script = '{
      '{1'b1, 20, "", 32'h8000_0000, 1'b1, 1'b1, status_res(0, 90, 32'h8000_0000)},
      '{1'b0, 1, "R\n", 32'h0, 1'b1, 1'b1, res_of(udcd_pkg::KIND_ENC_RESET, 0, 0, 0)},
      '{1'b0, 1, "\r", 32'h0, 1'b1, 1'b0, NO_RES},
      '{1'b0, 1, "~\n", 32'h0, 1'b1, 1'b1, res_of(udcd_pkg::KIND_UNKNOWN, 0, 0, 0)},
      '{1'b0, 1, "E~\377\r", 32'h0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1, "C:100,180\n", 32'h0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1, "C:\011\013\014-999,-5\n", 32'h0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 1, "C:5\n", 32'h0, 1'b1, 1'b1, res_of(udcd_pkg::KIND_BAD_C, 0, 0, 0)},
      '{1'b0, 1, "C;\n", 32'h0, 1'b1, 1'b1, res_of(udcd_pkg::KIND_UNKNOWN, 0, 0, 0)},
      '{1'b0, 64, "A", 32'h0, 1'b1, 1'b0, NO_RES},
      '{1'b0, 1, "\n", 32'h0, 1'b1, 1'b0, NO_RES}
    };

    foreach (script[r]) begin
      row = script[r];
      n = row.tick ? row.reps : row.reps * row.text.len();
      for (int k = 0; k < n; k++) begin
        if (row.tick) begin
          it = tick_of(row.enc);
        end else begin
          ch = row.text[k % row.text.len()];
          it = byte_of(ch == "~" ? CH_NUL : ch);
        end
        send_beat(it, row.typed, row.want_one && k == n - 1, row.want);
      end
    end
    drain();

    // minimum intervals, plus a long output hold
    configure(1, 1, 0, 0);
    hold_order++;
    run_random(14, 3);
    drain();

    configure(65535, 65535, 180, 255);
    run_random(8, 2);
    drain();

    configure($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(0, 255),
              $urandom_range(1, 254));
    quiet = 1'b1;
    run_random(8, 2);
    quiet = 1'b0;
    run_random(6, 2);
    drain();

    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (hold_served != hold_order) begin
      hold_served = hold_order;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < 16);
    end
  end

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    udcd_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: kind %0d", out_item_o.kind);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", want.kind, out_item_o.kind);
        compare_field("drive_duty", want.drive_duty, out_item_o.drive_duty);
        compare_field("steer_angle", want.steer_angle, out_item_o.steer_angle);
        compare_field("hold_ms", want.hold_ms, out_item_o.hold_ms);
        compare_field("report_speed", want.report_speed, out_item_o.report_speed);
        compare_field("report_steer", want.report_steer, out_item_o.report_steer);
        compare_field("report_encoder", want.report_encoder, out_item_o.report_encoder);
        compare_field("last", want.last, out_item_o.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
